### design/ssed_pkg.sv
// Package for the seven-segment effect driver: op codes, effect modes,
// segment constants and the digit font. No dependencies.
`default_nettype none

package ssed_pkg;

    localparam int unsigned SEG_W  = 7;
    localparam int unsigned STEP_W = 7;
    localparam int unsigned DIV_W  = 3;

    typedef logic [SEG_W-1:0]  seg_t;
    typedef logic [STEP_W-1:0] step_t;
    typedef logic [DIV_W-1:0]  div_t;
    typedef logic [1:0]        op_t;
    typedef logic [3:0]        digit_t;
    typedef logic [2:0]        sel_t;

    localparam op_t OP_SHOW   = 2'd0;
    localparam op_t OP_SELECT = 2'd1;
    localparam op_t OP_TICK   = 2'd2;

    typedef enum logic [2:0] {
        MODE_NONE  = 3'd0,
        MODE_BLINK = 3'd1,
        MODE_RROT  = 3'd2,
        MODE_LROT  = 3'd3,
        MODE_SUP   = 3'd4,
        MODE_SDOWN = 3'd5
    } mode_t;

    localparam div_t  BLINK_RELOAD = 3'd4;
    localparam div_t  SHIFT_RELOAD = 3'd2;
    localparam step_t SHIFT_PHASES = 7'd3;
    localparam step_t RROT_FIRST   = 7'h01;
    localparam step_t RROT_WRAP    = 7'h40;
    localparam step_t LROT_FIRST   = 7'h20;

    localparam seg_t BAR_TOP    = 7'h01;
    localparam seg_t BAR_MIDDLE = 7'h40;
    localparam seg_t BAR_BOTTOM = 7'h08;
    localparam seg_t SEG_BLANK  = 7'h00;

    // Segment pattern of a digit, bit 0 is segment a; non-decimal codes are blank.
    function automatic seg_t font_of(input digit_t d);
        seg_t s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    // Bar for a shift phase; up runs bottom, middle, top and down the reverse.
    function automatic seg_t bar_of(input logic up, input logic [1:0] phase);
        seg_t s;
        case (phase)
            2'd0:    s = up ? BAR_BOTTOM : BAR_TOP;
            2'd1:    s = BAR_MIDDLE;
            default: s = up ? BAR_TOP : BAR_BOTTOM;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### design/ssed_if.sv
// Valid/ready channel interfaces for the seven-segment effect driver.
// Depends on ssed_pkg for payload types.
`default_nettype none

interface ssed_in_if;
    logic              valid;
    logic              ready;
    ssed_pkg::op_t     op;
    ssed_pkg::digit_t  digit;
    ssed_pkg::sel_t    effect_sel;

    modport source (output valid, output op, output digit, output effect_sel, input ready);
    modport sink   (input valid, input op, input digit, input effect_sel, output ready);
endinterface

interface ssed_out_if;
    logic            valid;
    logic            ready;
    ssed_pkg::seg_t  segments;

    modport source (output valid, output segments, input ready);
    modport sink   (input valid, input segments, output ready);
endinterface

`default_nettype wire

### design/seven_segment_effect_driver.sv
// Seven-segment effect driver: top level with APB register port.
// Depends on ssed_pkg and the channel interfaces in ssed_if.sv.
// The segment result of an accepted transaction is registered and shown in the cycle after acceptance.
// Throughput: one transaction per cycle; the single output register stalls
// the input only while a result is held and out_ch.ready is low.
// Reset: mode none, digit 0, step 0, tick divider 4, pattern blank,
// common_level 0; no result pending; the segment output register is not reset.
`default_nettype none

module seven_segment_effect_driver (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    ssed_in_if.sink          in_ch,
    ssed_out_if.source       out_ch
);

    logic               common_level_reg;
    ssed_pkg::mode_t    mode_reg,       mode_next;
    ssed_pkg::digit_t   held_digit_reg, held_digit_next;
    ssed_pkg::step_t    step_reg,       step_next;
    ssed_pkg::div_t     div_reg,        div_next;
    ssed_pkg::seg_t     pattern_reg,    pattern_next;
    ssed_pkg::seg_t     seg_reg;
    logic               out_valid_reg;
    ssed_pkg::step_t    step_adj;
    logic               in_fire;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 3'd0);
    assign prdata = (paddr == 3'd0) ? {31'd0, common_level_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            common_level_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            common_level_reg <= pwdata[0];
        end
    end

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        mode_next       = mode_reg;
        held_digit_next = held_digit_reg;
        step_next       = step_reg;
        div_next        = div_reg;
        pattern_next    = pattern_reg;
        step_adj        = step_reg;
        case (in_ch.op)
            ssed_pkg::OP_SHOW:
            begin
                pattern_next    = ssed_pkg::font_of(in_ch.digit);
                held_digit_next = in_ch.digit;
            end
            ssed_pkg::OP_SELECT:
            begin
                unique case (in_ch.effect_sel)
                    ssed_pkg::MODE_BLINK:
                    begin
                        mode_next = ssed_pkg::MODE_BLINK;
                        step_next = 7'd1;
                    end
                    ssed_pkg::MODE_RROT:
                    begin
                        mode_next = ssed_pkg::MODE_RROT;
                        step_next = ssed_pkg::RROT_FIRST;
                    end
                    ssed_pkg::MODE_LROT:
                    begin
                        mode_next = ssed_pkg::MODE_LROT;
                        step_next = ssed_pkg::LROT_FIRST;
                    end
                    ssed_pkg::MODE_SUP:
                    begin
                        mode_next = ssed_pkg::MODE_SUP;
                        step_next = '0;
                    end
                    ssed_pkg::MODE_SDOWN:
                    begin
                        mode_next = ssed_pkg::MODE_SDOWN;
                        step_next = '0;
                    end
                    default:
                    begin
                        mode_next    = ssed_pkg::MODE_NONE;
                        pattern_next = ssed_pkg::font_of(held_digit_reg);
                    end
                endcase
            end
            ssed_pkg::OP_TICK:
            begin
                unique case (mode_reg)
                    ssed_pkg::MODE_BLINK:
                    begin
                        if (div_reg == '0)
                        begin
                            if (step_reg != '0)
                            begin
                                pattern_next = ssed_pkg::SEG_BLANK;
                                step_next    = '0;
                            end
                            else
                            begin
                                pattern_next = ssed_pkg::font_of(held_digit_reg);
                                step_next    = 7'd1;
                            end
                            div_next = ssed_pkg::BLINK_RELOAD;
                        end
                        else
                        begin
                            div_next = div_reg - 3'd1;
                        end
                    end
                    ssed_pkg::MODE_RROT:
                    begin
                        step_adj     = (step_reg == ssed_pkg::RROT_WRAP)
                                       ? ssed_pkg::RROT_FIRST : step_reg;
                        pattern_next = step_adj;
                        step_next    = {step_adj[5:0], 1'b0};
                    end
                    ssed_pkg::MODE_LROT:
                    begin
                        step_adj     = (step_reg == '0) ? ssed_pkg::LROT_FIRST : step_reg;
                        pattern_next = step_adj;
                        step_next    = {1'b0, step_adj[6:1]};
                    end
                    ssed_pkg::MODE_SUP, ssed_pkg::MODE_SDOWN:
                    begin
                        if (div_reg == '0)
                        begin
                            step_adj     = (step_reg >= ssed_pkg::SHIFT_PHASES)
                                           ? '0 : step_reg;
                            pattern_next = ssed_pkg::bar_of(mode_reg == ssed_pkg::MODE_SUP,
                                                            step_adj[1:0]);
                            step_next    = step_adj + 7'd1;
                            div_next     = ssed_pkg::SHIFT_RELOAD;
                        end
                        else
                        begin
                            div_next = div_reg - 3'd1;
                        end
                    end
                    default:
                    begin
                        step_adj = step_reg;
                    end
                endcase
            end
            default:
            begin
                step_adj = step_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= ssed_pkg::MODE_NONE;
            held_digit_reg <= '0;
            step_reg       <= '0;
            div_reg        <= ssed_pkg::BLINK_RELOAD;
            pattern_reg    <= ssed_pkg::SEG_BLANK;
        end
        else if (in_fire)
        begin
            mode_reg       <= mode_next;
            held_digit_reg <= held_digit_next;
            step_reg       <= step_next;
            div_reg        <= div_next;
            pattern_reg    <= pattern_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            seg_reg <= common_level_reg ? ~pattern_next : pattern_next;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.segments = seg_reg;

endmodule

`default_nettype wire
